// ===== src/chpl_pkg.sv =====
// ============================================================================
// chpl_pkg
// Shared types, codes and defaults for the chained hash page lookup block.
// ============================================================================
package chpl_pkg;

    localparam int unsigned MAX_BUCKETS_DEF = 512;
    localparam int unsigned MAX_SLOTS_DEF   = 512 / 2;
    localparam int unsigned NUM_TYPES_DEF   = 2;

    localparam int unsigned KEY_W      = 48;
    localparam int unsigned SUM_W      = 33;
    localparam int unsigned DIV_CNT_W  = 6;
    localparam int unsigned BCNT_CFG_W = 10;
    localparam int unsigned SCNT_CFG_W = 9;

    localparam logic [BCNT_CFG_W-1:0] BCNT_RST = 10'd512;
    localparam logic [SCNT_CFG_W-1:0] SCNT_RST = 9'd256;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_DELETE = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SLOT  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_BCNT0 = 2'd0,
        CFG_BCNT1 = 2'd1,
        CFG_SCNT0 = 2'd2,
        CFG_SCNT1 = 2'd3
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic    load_op;
        logic    div_start;
        logic    div_step;
        logic    clr_wr;
        logic    head_rd;
        logic    ins_wr;
        logic    walk_init;
        logic    walk_rd;
        logic    walk_adv;
        logic    del_wr;
        logic    out_load;
        t_status out_status;
        logic    out_found;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  type_bad;
        logic  slot_bad;
        logic  div_done;
        logic  clr_last;
        logic  walk_end;
        logic  key_match;
        logic  out_busy;
    } t_sts;

endpackage

// ===== src/chpl_dp.sv =====
// ============================================================================
// chpl_dp
// Datapath: config registers, bucket divider, head/link/key memories, walk
// registers and the result register.
// ============================================================================
module chpl_dp
    import chpl_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int unsigned MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int unsigned NUM_TYPES   = NUM_TYPES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_kind,
    input  logic        i_buffer_type,
    input  logic [15:0] i_volume_number,
    input  logic [31:0] i_page_number,
    input  logic [7:0]  i_slot_index,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_out_stall,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [7:0]  o_found_slot
);

    localparam int unsigned HDEPTH = NUM_TYPES * MAX_BUCKETS;
    localparam int unsigned LDEPTH = NUM_TYPES * MAX_SLOTS;
    localparam int unsigned HA_W   = $clog2(HDEPTH);
    localparam int unsigned LA_W   = $clog2(LDEPTH);
    localparam int unsigned SW     = $clog2(MAX_SLOTS);
    localparam int unsigned BI_W   = $clog2(MAX_BUCKETS);
    localparam int unsigned STP_W  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned BC_W   = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned SC_W   = $clog2(MAX_SLOTS + 1);
    localparam int unsigned EBW    = (BC_W > BCNT_CFG_W) ? BC_W : BCNT_CFG_W;
    localparam int unsigned ESW    = (SC_W > SCNT_CFG_W) ? SC_W : SCNT_CFG_W;

    // config
    logic [BCNT_CFG_W-1:0] r_bcnt0, r_bcnt1;
    logic [SCNT_CFG_W-1:0] r_scnt0, r_scnt1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt0 <= BCNT_RST;
            r_bcnt1 <= BCNT_RST;
            r_scnt0 <= SCNT_RST;
            r_scnt1 <= SCNT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BCNT0: r_bcnt0 <= i_cfg_data;
                CFG_BCNT1: r_bcnt1 <= i_cfg_data;
                CFG_SCNT0: r_scnt0 <= i_cfg_data[SCNT_CFG_W-1:0];
                CFG_SCNT1: r_scnt1 <= i_cfg_data[SCNT_CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    // latched operation
    t_kind          r_kind;
    logic           r_type;
    logic [KEY_W-1:0] r_key;
    logic [7:0]     r_sidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_kind <= t_kind'(i_kind);
            r_type <= i_buffer_type;
            r_key  <= {i_volume_number, i_page_number};
            r_sidx <= i_slot_index;
        end
    end

    // effective counts
    logic [EBW-1:0] bcnt_raw, bcnt_eff;
    logic [ESW-1:0] scnt_raw, scnt_eff;

    always_comb begin
        bcnt_raw = EBW'(r_type ? r_bcnt1 : r_bcnt0);
        scnt_raw = ESW'(r_type ? r_scnt1 : r_scnt0);
        if (bcnt_raw == '0) begin
            bcnt_eff = EBW'(1);
        end else if (bcnt_raw > EBW'(MAX_BUCKETS)) begin
            bcnt_eff = EBW'(MAX_BUCKETS);
        end else begin
            bcnt_eff = bcnt_raw;
        end
        scnt_eff = (scnt_raw > ESW'(MAX_SLOTS)) ? ESW'(MAX_SLOTS) : scnt_raw;
    end

    // restoring remainder, one dividend bit per cycle
    logic [EBW-1:0]       r_rem;
    logic [SUM_W-1:0]     r_dvd;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [EBW:0]         rem_shift;

    assign rem_shift = {r_rem, r_dvd[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_dvd     <= SUM_W'(r_key[KEY_W-1:32]) + SUM_W'(r_key[31:0]);
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[SUM_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (rem_shift >= {1'b0, bcnt_eff}) begin
                r_rem <= EBW'(rem_shift - {1'b0, bcnt_eff});
            end else begin
                r_rem <= EBW'(rem_shift);
            end
        end
    end

    // addresses
    logic [HA_W-1:0] head_addr;
    logic [SW-1:0]   sidx_s;
    logic [SW-1:0]   r_cur, r_prev;
    logic            r_cur_ok, r_has_prev;
    logic [STP_W-1:0] r_steps;
    logic [HA_W-1:0] r_clr_addr;

    assign head_addr = HA_W'(r_type) * HA_W'(MAX_BUCKETS) + HA_W'(r_rem[BI_W-1:0]);
    assign sidx_s    = SW'(r_sidx);

    function automatic logic [LA_W-1:0] slot_addr(input logic t, input logic [SW-1:0] s);
        slot_addr = LA_W'(t) * LA_W'(MAX_SLOTS) + LA_W'(s);
    endfunction

    // chain link and key read data
    logic [SW:0]      r_link_q;
    logic [KEY_W-1:0] r_key_q;

    // bucket heads: {valid, slot}
    logic [SW:0] head_mem [HDEPTH];
    logic [SW:0] r_head_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            head_mem[r_clr_addr] <= '0;
        end else if (i_cmd.ins_wr) begin
            head_mem[head_addr] <= {1'b1, sidx_s};
        end else if (i_cmd.del_wr && !r_has_prev) begin
            head_mem[head_addr] <= r_link_q;
        end
        if (i_cmd.head_rd) begin
            r_head_q <= head_mem[head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= (r_clr_addr == HA_W'(HDEPTH - 1)) ? '0 : r_clr_addr + HA_W'(1);
        end
    end

    // chain links and keys
    logic [SW:0]      link_mem [LDEPTH];
    logic [KEY_W-1:0] key_mem  [LDEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            link_mem[slot_addr(r_type, sidx_s)] <= r_head_q;
        end else if (i_cmd.del_wr && r_has_prev) begin
            link_mem[slot_addr(r_type, r_prev)] <= r_link_q;
        end
        if (i_cmd.walk_rd) begin
            r_link_q <= link_mem[slot_addr(r_type, r_cur)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            key_mem[slot_addr(r_type, sidx_s)] <= r_key;
        end
        if (i_cmd.walk_rd) begin
            r_key_q <= key_mem[slot_addr(r_type, r_cur)];
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_cur      <= r_head_q[SW-1:0];
            r_cur_ok   <= r_head_q[SW];
            r_has_prev <= 1'b0;
            r_steps    <= '0;
        end else if (i_cmd.walk_adv) begin
            r_prev     <= r_cur;
            r_has_prev <= 1'b1;
            r_cur      <= r_link_q[SW-1:0];
            r_cur_ok   <= r_link_q[SW];
            r_steps    <= r_steps + STP_W'(1);
        end
    end

    // result register
    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_found;
    logic [7:0] r_found_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status     <= i_cmd.out_status;
            r_found      <= i_cmd.out_found;
            r_found_slot <= i_cmd.out_found ? 8'(r_cur) : 8'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_found_slot = r_found_slot;

    // status to controller
    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.type_bad  = (32'(r_type) >= NUM_TYPES);
        o_sts.slot_bad  = (ESW'(r_sidx) >= scnt_eff);
        o_sts.div_done  = (r_div_cnt == DIV_CNT_W'(SUM_W));
        o_sts.clr_last  = (r_clr_addr == HA_W'(HDEPTH - 1));
        o_sts.walk_end  = !r_cur_ok || (r_steps == STP_W'(MAX_SLOTS));
        o_sts.key_match = (r_key_q == r_key);
        o_sts.out_busy  = r_out_valid && i_out_stall;
    end

endmodule

// ===== src/chpl_ctrl.sv =====
// ============================================================================
// chpl_ctrl
// Sequencer for clear sweep, bucket divide, head access and chain walk.
// ============================================================================
module chpl_ctrl
    import chpl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_HEAD_USE,
        S_WALK_RD,
        S_WALK_CMP,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_clr_op, n_clr_op;
    t_status r_res_status, n_res_status;
    logic    r_res_found, n_res_found;

    always_comb begin
        n_state      = r_state;
        n_clr_op     = r_clr_op;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        o_cmd        = '0;
        o_cmd.out_status = r_res_status;
        o_cmd.out_found  = r_res_found;

        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_op = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status = ST_OK;
                n_res_found  = 1'b0;
                priority if (i_sts.kind == K_CLEAR) begin
                    n_clr_op = 1'b1;
                    n_state  = S_CLR;
                end else if (i_sts.type_bad) begin
                    n_res_status = (i_sts.kind == K_INSERT) ? ST_BAD_SLOT : ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (i_sts.kind == K_INSERT && i_sts.slot_bad) begin
                    n_res_status = ST_BAD_SLOT;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_HEAD_USE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_HEAD_USE: begin
                if (i_sts.kind == K_INSERT) begin
                    o_cmd.ins_wr = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (i_sts.walk_end) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_sts.key_match) begin
                    if (i_sts.kind == K_DELETE) begin
                        o_cmd.del_wr = 1'b1;
                    end else begin
                        n_res_found = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WALK_RD;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_clr_op       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_op     <= 1'b0;
            r_res_status <= ST_OK;
            r_res_found  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_op     <= n_clr_op;
            r_res_status <= n_res_status;
            r_res_found  <= n_res_found;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/chained_hash_page_lookup_top.sv =====
// ============================================================================
// chained_hash_page_lookup_top
// Chained hash table mapping (volume, page) keys to buffer slots per pool type.
// ============================================================================
// One operation is taken at a time and answers with exactly one result
// transaction. After reset, and on every clear operation, the block sweeps
// all NUM_TYPES * MAX_BUCKETS entries of the bucket head memory one entry per
// cycle and holds o_in_stall high during the sweep; config writes are taken
// at any time. Lookup, insert and delete first reduce (volume + page) modulo
// the bucket count with a bit-serial divider, then read the bucket head.
// Insert then writes the new head and the slot's link and key and finishes.
// Lookup and delete walk the chain, reading the link/key memory and then
// comparing for each visited slot. A rejected insert or an unknown type
// answers straight from decode. A finished result waits in the output
// register while i_out_stall is high, and the next transaction is accepted
// meanwhile.
module chained_hash_page_lookup_top
    import chpl_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int unsigned MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int unsigned NUM_TYPES   = NUM_TYPES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_buffer_type,
    input  logic [15:0] i_volume_number,
    input  logic [31:0] i_page_number,
    input  logic [7:0]  i_slot_index,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [7:0]  o_found_slot,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // config registers always take the write
    assign o_cfg_ready = 1'b1;

    chpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    chpl_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_SLOTS   (MAX_SLOTS),
        .NUM_TYPES   (NUM_TYPES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_buffer_type   (i_buffer_type),
        .i_volume_number (i_volume_number),
        .i_page_number   (i_page_number),
        .i_slot_index    (i_slot_index),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_found_slot    (o_found_slot)
    );

endmodule
